### rtl/tcc_pkg.sv
// Shared types and constants for the text console cursor writer.
// Holds field widths, character codes, register indexes and the structs
// passed between the cursor engine, the row table and the register block.
package tcc_pkg;

  // Fixed field widths
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CODE_W = 8;
  localparam int CLR_W  = 4;

  // Default screen geometry
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // Register port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Control characters
  localparam logic [CODE_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CODE_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CODE_W-1:0] CH_RETURN    = 8'd13;

  // Register reset values
  localparam logic [CLR_W-1:0] FG_RESET = 4'hF;
  localparam logic [CLR_W-1:0] BG_RESET = 4'h0;

  // Register indexes (word address bit 2)
  typedef enum logic [0:0] {
    REG_FOREGROUND = 1'b0,
    REG_BACKGROUND = 1'b1
  } reg_index_t;

  // Colour registers
  typedef struct packed {
    logic [CLR_W-1:0] bg;
    logic [CLR_W-1:0] fg;
  } colour_cfg_t;

  // Update command for the row table, valid for one cycle
  typedef struct packed {
    logic             wr_en;
    logic [ROW_W-1:0] wr_row;
    logic [COL_W-1:0] wr_col;
    logic             scroll;
  } tbl_cmd_t;

endpackage

### rtl/text_console_cursor_writer.sv
// Text console cursor writer: takes one word per clock when not stalled (a
// character code or a clear command) and returns one result word per input,
// registered and shown in the cycle after the word is accepted, holding the
// cell write, scroll and clear requests and the new cursor. A new word is
// accepted every cycle while the result register is empty or being taken.
// The row table is cleared by reset at once.
// Depends on tcc_pkg, tcc_regs and tcc_row_table.
module text_console_cursor_writer #(
  parameter int COLUMNS = tcc_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcc_pkg::DEF_ROWS
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tcc_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [tcc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [tcc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  // Input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            action,
  input  logic [tcc_pkg::CODE_W-1:0]      char_code,
  // Result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            cell_write,
  output logic [tcc_pkg::ROW_W-1:0]       cell_row,
  output logic [tcc_pkg::COL_W-1:0]       cell_col,
  output logic [tcc_pkg::CODE_W-1:0]      cell_code,
  output logic [tcc_pkg::CODE_W-1:0]      cell_attribute,
  output logic                            scroll_up,
  output logic                            clear_all,
  output logic [tcc_pkg::ROW_W-1:0]       cursor_row_now,
  output logic [tcc_pkg::COL_W-1:0]       cursor_col_now
);
  import tcc_pkg::*;

  localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

  colour_cfg_t      cfg;
  tbl_cmd_t         tbl_cmd;
  logic             in_fire;
  logic [ROW_W-1:0] cursor_row, cursor_row_next;
  logic [COL_W-1:0] cursor_col, cursor_col_next;
  logic [ROW_W-1:0] prev_row;
  logic [COL_W-1:0] prev_end;
  logic             advance;
  logic             wr;
  logic [ROW_W-1:0] wrow;
  logic [COL_W-1:0] wcol;
  logic [CODE_W-1:0] wcode;
  logic             tbl_wr;
  logic             scroll;
  logic             clr;

  tcc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tcc_row_table #(.ROWS(ROWS)) u_row_table (
    .clk    (clk),
    .rst    (rst),
    .cmd    (tbl_cmd),
    .rd_row (prev_row),
    .rd_col (prev_end)
  );

  // Handshake: the result register frees up when it is empty or being taken.
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign prev_row = cursor_row - ROW_W'(1);

  // Cursor update for one word.
  always_comb begin
    cursor_row_next = cursor_row;
    cursor_col_next = cursor_col;
    advance = 1'b0;
    wr      = 1'b0;
    wrow    = '0;
    wcol    = '0;
    wcode   = '0;
    tbl_wr  = 1'b0;
    scroll  = 1'b0;
    clr     = 1'b0;
    if (action) begin
      clr             = 1'b1;
      cursor_row_next = '0;
      cursor_col_next = '0;
    end else begin
      unique case (char_code)
        CH_NEWLINE: begin
          cursor_col_next = '0;
          advance         = 1'b1;
        end
        CH_RETURN: begin
          cursor_col_next = '0;
        end
        CH_BACKSPACE: begin
          if (cursor_col != '0 || cursor_row != '0) begin
            if (cursor_col == '0) begin
              cursor_row_next = prev_row;
              cursor_col_next = prev_end;
            end else begin
              cursor_col_next = cursor_col - COL_W'(1);
            end
            wr   = 1'b1;
            wrow = cursor_row_next;
            wcol = cursor_col_next;
          end
        end
        default: begin
          wr     = 1'b1;
          wrow   = cursor_row;
          wcol   = cursor_col;
          wcode  = char_code;
          tbl_wr = 1'b1;
          if (cursor_col == LAST_COL) begin
            cursor_col_next = '0;
            advance         = 1'b1;
          end else begin
            cursor_col_next = cursor_col + COL_W'(1);
          end
        end
      endcase
    end
    // Moving past the last row scrolls and parks the cursor at its start.
    if (advance) begin
      if (cursor_row == LAST_ROW) begin
        scroll          = 1'b1;
        cursor_row_next = LAST_ROW;
        cursor_col_next = '0;
      end else begin
        cursor_row_next = cursor_row + ROW_W'(1);
      end
    end
  end

  // Row table command, only on an accepted word.
  always_comb begin
    tbl_cmd.wr_en  = in_fire && tbl_wr;
    tbl_cmd.wr_row = cursor_row;
    tbl_cmd.wr_col = cursor_col;
    tbl_cmd.scroll = in_fire && scroll;
  end

  // Cursor registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_row <= '0;
      cursor_col <= '0;
    end else if (in_fire) begin
      cursor_row <= cursor_row_next;
      cursor_col <= cursor_col_next;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cell_write     <= wr;
      cell_row       <= wrow;
      cell_col       <= wcol;
      cell_code      <= wcode;
      cell_attribute <= wr ? {cfg.bg, cfg.fg} : '0;
      scroll_up      <= scroll;
      clear_all      <= clr;
      cursor_row_now <= cursor_row_next;
      cursor_col_now <= cursor_col_next;
    end
  end

  // The cursor always stays on the screen.
  assert property (@(posedge clk) disable iff (rst)
    (cursor_row <= LAST_ROW) && (cursor_col <= LAST_COL))
    else $error("cursor left the screen");

  // A scroll result leaves the cursor at the start of the bottom row.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && scroll_up) |-> (cursor_row_now == LAST_ROW && cursor_col_now == '0))
    else $error("scroll result with cursor off the bottom row start");

  // A clear result homes the cursor and writes no cell.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && clear_all) |->
      (cursor_row_now == '0 && cursor_col_now == '0 && !cell_write && !scroll_up))
    else $error("clear result not homed");

  // The cursor registers follow the reported cursor after an accepted word.
  assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (cursor_row == cursor_row_now && cursor_col == cursor_col_now))
    else $error("cursor registers differ from reported cursor");

  // Without a cell write the cell fields read as zero.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !cell_write) |->
      (cell_row == '0 && cell_col == '0 && cell_code == '0 && cell_attribute == '0))
    else $error("cell fields set without a cell write");

endmodule

### rtl/tcc_regs.sv
// Colour configuration registers behind an APB-style port.
// Depends on tcc_pkg for widths, reset values and register indexes.
module tcc_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tcc_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [tcc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [tcc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output tcc_pkg::colour_cfg_t            cfg
);
  import tcc_pkg::*;

  logic       wr_fire;
  reg_index_t idx;

  // Registers sit on word boundaries; bit 2 picks the register.
  assign idx     = reg_index_t'(paddr[2]);
  assign pready  = 1'b1;
  assign wr_fire = psel && penable && pwrite && pready;

  // Register writes on the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fg <= FG_RESET;
      cfg.bg <= BG_RESET;
    end else if (wr_fire) begin
      unique case (idx)
        REG_FOREGROUND: cfg.fg <= pwdata[CLR_W-1:0];
        REG_BACKGROUND: cfg.bg <= pwdata[CLR_W-1:0];
        default: ;
      endcase
    end
  end

  // Read data.
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_FOREGROUND: prdata[CLR_W-1:0] = cfg.fg;
      REG_BACKGROUND: prdata[CLR_W-1:0] = cfg.bg;
      default: ;
    endcase
  end

endmodule

### rtl/tcc_row_table.sv
// Per-row record of the last written column, one register per row.
// Depends on tcc_pkg; supports a single write and a one-row shift per cycle.
module tcc_row_table #(
  parameter int ROWS = tcc_pkg::DEF_ROWS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  tcc_pkg::tbl_cmd_t           cmd,
  input  logic [tcc_pkg::ROW_W-1:0]   rd_row,
  output logic [tcc_pkg::COL_W-1:0]   rd_col
);
  import tcc_pkg::*;

  localparam int IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [COL_W-1:0] ends      [ROWS];
  logic [COL_W-1:0] written   [ROWS];
  logic [COL_W-1:0] ends_next [ROWS];

  // Apply the write first, then the scroll shift on top of it.
  always_comb begin
    for (int i = 0; i < ROWS; i++) begin
      written[i] = (cmd.wr_en && (cmd.wr_row == ROW_W'(i))) ? cmd.wr_col : ends[i];
    end
    for (int i = 0; i < ROWS - 1; i++) begin
      ends_next[i] = cmd.scroll ? written[i + 1] : written[i];
    end
    ends_next[ROWS-1] = cmd.scroll ? '0 : written[ROWS-1];
  end

  // Table registers, cleared at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ROWS; i++) begin
        ends[i] <= '0;
      end
    end else begin
      for (int i = 0; i < ROWS; i++) begin
        ends[i] <= ends_next[i];
      end
    end
  end

  // Read port; rows outside the table read as zero.
  assign rd_col = (int'(rd_row) < ROWS) ? ends[rd_row[IDX_W-1:0]] : '0;

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for text_console_cursor_writer: a short scripted run, then random
// keystroke streams under several colour settings and flow-control patterns.
// Depends on tcc_pkg and the writer RTL; results are checked against a cursor predictor.
module tb_top;
  import tcc_pkg::*;

  localparam int COLS       = DEF_COLUMNS;
  localparam int NROWS      = DEF_ROWS;
  localparam int AW         = APB_ADDR_W;
  localparam int QUIET_MAX  = 2000;
  localparam int PHASES     = 8;
  localparam int PHASE_KEYS = 140;

  typedef struct packed {
    logic              wr;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [CODE_W-1:0] code;
    logic [7:0]        attr;
    logic              scroll;
    logic              clr;
    logic [ROW_W-1:0]  crow;
    logic [COL_W-1:0]  ccol;
  } cell_result_t;

  typedef struct packed {
    logic              act;
    logic [CODE_W-1:0] code;
  } keystroke_t;

  typedef struct {
    logic              act;
    logic [CODE_W-1:0] code;
    int                reps;
    bit                typed;
    cell_result_t      want;
  } script_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [AW-1:0]         paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  action = 1'b0;
  logic [CODE_W-1:0]     char_code = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  cell_write;
  logic [ROW_W-1:0]      cell_row;
  logic [COL_W-1:0]      cell_col;
  logic [CODE_W-1:0]     cell_code;
  logic [CODE_W-1:0]     cell_attribute;
  logic                  scroll_up;
  logic                  clear_all;
  logic [ROW_W-1:0]      cursor_row_now;
  logic [COL_W-1:0]      cursor_col_now;

  // Predictor state: cursor, per-row end column and the colour registers.
  int               cur_row = 0;
  int               cur_col = 0;
  int               line_end [NROWS];
  logic [CLR_W-1:0] fg_colour = FG_RESET;
  logic [CLR_W-1:0] bg_colour = BG_RESET;

  cell_result_t cells_due [$];
  keystroke_t   keys_pending [$];
  script_row_t  script_rows [$];
  int           faults = 0;
  int           send_idle = 0;
  int           recv_stall = 0;
  int           hold_left = 0;
  int           quiet_cycles = 0;

  text_console_cursor_writer DUT (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    foreach (line_end[i]) line_end[i] = 0;
  end

  // Works out the result of one word and moves the predicted cursor on.
  function automatic cell_result_t advance_cursor(input logic act, input logic [CODE_W-1:0] ch);
    cell_result_t r;
    r = '0;
    if (act) begin
      r.clr = 1'b1;
      cur_row = 0;
      cur_col = 0;
    end else if (ch == CH_NEWLINE) begin
      cur_col = 0;
      cur_row++;
    end else if (ch == CH_RETURN) begin
      cur_col = 0;
    end else if (ch == CH_BACKSPACE) begin
      // At home a backspace does nothing at all.
      if (cur_col != 0 || cur_row != 0) begin
        if (cur_col == 0) begin
          cur_row--;
          cur_col = line_end[cur_row];
        end else begin
          cur_col--;
        end
        r.wr   = 1'b1;
        r.row  = ROW_W'(cur_row);
        r.col  = COL_W'(cur_col);
        r.attr = {bg_colour, fg_colour};
      end
    end else begin
      r.wr   = 1'b1;
      r.row  = ROW_W'(cur_row);
      r.col  = COL_W'(cur_col);
      r.code = ch;
      r.attr = {bg_colour, fg_colour};
      line_end[cur_row] = cur_col;
      cur_col++;
      if (cur_col >= COLS) begin
        cur_col = 0;
        cur_row++;
      end
    end
    // Falling off the bottom scrolls the row table up by one line.
    if (cur_row >= NROWS) begin
      r.scroll = 1'b1;
      for (int i = 0; i + 1 < NROWS; i++) line_end[i] = line_end[i + 1];
      line_end[NROWS - 1] = 0;
      cur_row = NROWS - 1;
      cur_col = 0;
    end
    r.crow = ROW_W'(cur_row);
    r.ccol = COL_W'(cur_col);
    return r;
  endfunction

  function automatic cell_result_t outcome(input int wr, input int row, input int col,
                                           input int code, input int attr, input int scroll,
                                           input int clr, input int crow, input int ccol);
    cell_result_t r;
    r.wr = 1'(wr);         r.row = ROW_W'(row);   r.col = COL_W'(col);
    r.code = CODE_W'(code); r.attr = 8'(attr);    r.scroll = 1'(scroll);
    r.clr = 1'(clr);       r.crow = ROW_W'(crow); r.ccol = COL_W'(ccol);
    return r;
  endfunction

  function automatic string describe(input cell_result_t r);
    return $sformatf("write=%0d cell=%0d,%0d code=%h attr=%h scroll=%0d clear=%0d cursor=%0d,%0d",
                     r.wr, r.row, r.col, r.code, r.attr, r.scroll, r.clr, r.crow, r.ccol);
  endfunction

  function automatic void add_step(input logic act, input logic [CODE_W-1:0] code,
                                   input int reps, input bit typed, input cell_result_t want);
    script_row_t s;
    s.act = act; s.code = code; s.reps = reps; s.typed = typed; s.want = want;
    script_rows.push_back(s);
  endfunction

  function automatic logic [CODE_W-1:0] printable();
    logic [CODE_W-1:0] c;
    do c = CODE_W'($urandom_range(255));
    while (c == CH_NEWLINE || c == CH_RETURN || c == CH_BACKSPACE);
    return c;
  endfunction

  // Queues one burst of typing: mostly text lines, with backspace runs,
  // newline runs, clears and some raw noise mixed in.
  function automatic void plan_burst();
    int pick, len;
    pick = $urandom_range(99);
    if (pick < 60) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(170, 78) : $urandom_range(30);
      repeat (len) keys_pending.push_back({1'b0, printable()});
      pick = $urandom_range(9);
      if (pick < 7) keys_pending.push_back({1'b0, CH_NEWLINE});
      else if (pick < 9) keys_pending.push_back({1'b0, CH_RETURN});
    end else if (pick < 75) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(90, 30) : $urandom_range(6, 1);
      repeat (len) keys_pending.push_back({1'b0, CH_BACKSPACE});
    end else if (pick < 80) begin
      keys_pending.push_back({1'b1, CODE_W'($urandom_range(255))});
    end else if (pick < 87) begin
      repeat ($urandom_range(30, 1)) keys_pending.push_back({1'b0, CH_NEWLINE});
    end else begin
      repeat ($urandom_range(8, 1))
        keys_pending.push_back({1'($urandom_range(7) == 0), CODE_W'($urandom_range(255))});
    end
  endfunction

  task automatic note_fault(input string msg);
    faults++;
    if (faults <= 10) $display("%s", msg);
  endtask

  // Offers one word on the input channel and records its expected result once taken.
  task automatic offer_key(input logic act, input logic [CODE_W-1:0] code,
                           input bit typed, input cell_result_t want);
    cell_result_t guess;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    char_code <= code;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    guess = advance_cursor(act, code);
    cells_due.push_back(typed ? want : guess);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (cells_due.size() != 0) @(negedge clk);
  endtask

  // One register access, setup then access phase; psel is left high.
  task automatic reg_access(input logic wr, input reg_index_t idx, input logic [CLR_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= AW'(4 * int'(idx));
    pwdata  <= APB_DATA_W'(val);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (!wr && prdata !== APB_DATA_W'(val))
      note_fault($sformatf("tb: register %0d read back %h, expected %h", idx, prdata, val));
    @(negedge clk);
  endtask

  // Colours change only with the writer idle: drain, let it settle, then write and read back.
  task automatic set_colours(input logic [CLR_W-1:0] fg, input logic [CLR_W-1:0] bg);
    drain_results();
    repeat (4) @(negedge clk);
    reg_access(1'b1, REG_FOREGROUND, fg);
    reg_access(1'b0, REG_FOREGROUND, fg);
    reg_access(1'b1, REG_BACKGROUND, bg);
    reg_access(1'b0, REG_BACKGROUND, bg);
    psel    <= 1'b0;
    penable <= 1'b0;
    fg_colour = fg;
    bg_colour = bg;
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // Each result word is compared with the oldest one due.
  always @(posedge clk) begin
    cell_result_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = {cell_write, cell_row, cell_col, cell_code, cell_attribute,
             scroll_up, clear_all, cursor_row_now, cursor_col_now};
      if (cells_due.size() == 0) begin
        note_fault({"tb: result with nothing due: ", describe(got)});
      end else begin
        want = cells_due.pop_front();
        if (got !== want)
          note_fault({"tb: result mismatch\n  expected ", describe(want),
                      "\n  actual   ", describe(got)});
      end
    end
  end

  // Watchdog: too long without any word moving on either channel or a register access.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_MAX) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int           target;
    int           sent;
    keystroke_t   k;
    logic [CLR_W-1:0] fgv, bgv;
    int           send_plan [4];
    int           stall_plan [4];
    send_plan  = '{0, 59, 0, 18};
    stall_plan = '{0, 0, 59, 18};

    // Scripted part, default colours (attribute 0F after reset).
    add_step(1'b0, CH_BACKSPACE, 1, 1'b1, outcome(0, 0, 0, 8'h00, 8'h00, 0, 0, 0, 0));
    add_step(1'b0, 8'h00, 1, 1'b1, outcome(1, 0, 0, 8'h00, 8'h0F, 0, 0, 0, 1));
    add_step(1'b0, 8'hFF, 1, 1'b1, outcome(1, 0, 1, 8'hFF, 8'h0F, 0, 0, 0, 2));
    add_step(1'b0, CH_BACKSPACE, 1, 1'b1, outcome(1, 0, 1, 8'h00, 8'h0F, 0, 0, 0, 1));
    add_step(1'b0, CH_RETURN, 1, 1'b1, outcome(0, 0, 0, 8'h00, 8'h00, 0, 0, 0, 0));
    add_step(1'b0, CH_NEWLINE, 1, 1'b1, outcome(0, 0, 0, 8'h00, 8'h00, 0, 0, 1, 0));
    // Backspace at column 0 falls back to the end of the row above.
    add_step(1'b0, CH_BACKSPACE, 1, 1'b0, '0);
    // A clear wins over the character code.
    add_step(1'b1, CH_NEWLINE, 1, 1'b1, outcome(0, 0, 0, 8'h00, 8'h00, 0, 1, 0, 0));
    // Fill row 0; the last column wraps to the next row.
    add_step(1'b0, 8'h41, 79, 1'b0, '0);
    add_step(1'b0, 8'h42, 1, 1'b1, outcome(1, 0, 79, 8'h42, 8'h0F, 0, 0, 1, 0));
    add_step(1'b0, CH_BACKSPACE, 1, 1'b0, '0);
    // Newlines down to the bottom row, then one more scrolls.
    add_step(1'b0, CH_NEWLINE, 24, 1'b0, '0);
    add_step(1'b0, CH_NEWLINE, 1, 1'b1, outcome(0, 0, 0, 8'h00, 8'h00, 1, 0, 24, 0));
    // Wrapping off the bottom row writes the cell and then scrolls.
    add_step(1'b0, 8'h78, 79, 1'b0, '0);
    add_step(1'b0, 8'h79, 1, 1'b1, outcome(1, 24, 79, 8'h79, 8'h0F, 1, 0, 24, 0));
    add_step(1'b0, CH_BACKSPACE, 1, 1'b0, '0);
    add_step(1'b1, CH_BACKSPACE, 1, 1'b1, outcome(0, 0, 0, 8'h00, 8'h00, 0, 1, 0, 0));
    add_step(1'b0, 8'h55, 1, 1'b0, '0);
    add_step(1'b0, 8'hAA, 1, 1'b0, '0);
    add_step(1'b0, 8'h7F, 1, 1'b0, '0);
    add_step(1'b0, 8'h80, 1, 1'b0, '0);
    add_step(1'b1, 8'h00, 1, 1'b0, '0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script_rows[i])
      for (int j = 0; j < script_rows[i].reps; j++)
        offer_key(script_rows[i].act, script_rows[i].code,
                  script_rows[i].typed && j == script_rows[i].reps - 1, script_rows[i].want);

    // Random part: each phase has its own colours and flow-control pattern.
    for (int p = 0; p < PHASES; p++) begin
      if (p < 4) begin
        fgv = (p == 1 || p == 3) ? 4'hF : 4'h0;
        bgv = (p == 1 || p == 2) ? 4'hF : 4'h0;
      end else begin
        fgv = CLR_W'($urandom_range(15));
        bgv = CLR_W'($urandom_range(15));
      end
      set_colours(fgv, bgv);
      send_idle  = send_plan[p % 4];
      recv_stall = stall_plan[p % 4];
      if (p == 2) begin
        // Long receiver hold-off while words keep coming, so the input backs up.
        @(posedge clk);
        hold_left = 300;
        @(negedge clk);
      end
      target = PHASE_KEYS;
      sent   = 0;
      while (sent < target) begin
        if (keys_pending.size() == 0) plan_burst();
        k = keys_pending.pop_front();
        offer_key(k.act, k.code, 1'b0, '0);
        sent++;
        if (p == 5 && sent == target / 2) drain_results();
      end
    end

    drain_results();
    repeat (8) @(negedge clk);
    if (faults == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

### files.f
rtl/tcc_pkg.sv
rtl/tcc_regs.sv
rtl/tcc_row_table.sv
rtl/text_console_cursor_writer.sv
tb/tb_top.sv
